// ===== src/minute_count_calendar_converter_defines.svh =====
// Assertion macros shared by the calendar converter modules.
// Expects clk_i and rst_ni in the scope of the using module.
`ifndef MINUTE_COUNT_CALENDAR_CONVERTER_DEFINES_SVH
`define MINUTE_COUNT_CALENDAR_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mcc_pkg.sv =====
// Package for the minute count calendar converter: widths, calendar
// constants, reciprocals for the constant divisions and the month table.
// No dependencies.
package mcc_pkg;

  localparam int NUM_STAGES = 8;

  localparam int COUNT_W  = 33;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int DAYS_W   = 23;
  localparam int TDATA_W  = 72;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 33'd5258964959;

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;
  localparam logic [10:0] MIN_PER_DAY = 11'd1440;

  // Rounded-up reciprocals; each is exact over the operand range it serves.
  localparam int SHIFT_45 = 34;
  localparam logic [28:0] RECIP_45 =
    29'(((64'd1 << SHIFT_45) + 64'd44) / 64'd45);
  localparam int SHIFT_400Y = 41;
  localparam logic [23:0] RECIP_400Y =
    24'(((64'd1 << SHIFT_400Y) + 64'd146096) / 64'd146097);
  localparam int SHIFT_1461 = 26;
  localparam logic [15:0] RECIP_1461 =
    16'(((64'd1 << SHIFT_1461) + 64'd1460) / 64'd1461);
  localparam int SHIFT_100 = 21;
  localparam logic [14:0] RECIP_100 =
    15'(((64'd1 << SHIFT_100) + 64'd99) / 64'd100);
  localparam int SHIFT_60 = 17;
  localparam logic [11:0] RECIP_60 =
    12'(((64'd1 << SHIFT_60) + 64'd59) / 64'd60);

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_ENCODE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic range_err;
  } mcc_tag_t;

  // Days in the year before the first day of month k (0 is January).
  function automatic logic [8:0] cum_days(input logic [3:0] k, input logic leap);
    logic [8:0] base;
    case (k)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap && (k >= 4'd2)};
  endfunction

endpackage

// ===== src/minute_count_calendar_converter.sv =====
// Top level of the minute count calendar converter (proleptic Gregorian).
// Depends on mcc_pkg, mcc_pipe_ctrl, mcc_time_split, mcc_date_split,
// mcc_count_path and the converter assertion macros.
//
//   channel  direction  beat carries
//   s_axis   in         command, then count or calendar fields to encode
//   m_axis   out        minute count, calendar fields, range flag
//
// Eight register stages between s_axis and m_axis.
// One beat per cycle sustained while m_axis is ready; every stage is a register with its own valid bit.
// A stall on m_axis backs up stage by stage; bubbles still take new beats.
// Reset clears the valid bits only; data registers are not reset.
`include "minute_count_calendar_converter_defines.svh"

module minute_count_calendar_converter
  import mcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [32:0] minute_count, [46:33] year_in, [50:47] month_in, [55:51] day_in,
  // [60:56] hour_in, [66:61] minute_in, [71:67] zero
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // [0] command
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [32:0] count_out, [46:33] year_out, [50:47] month_out, [55:51] day_out,
  // [60:56] hour_out, [66:61] minute_out, [71:67] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic               m_axis_tuser
);

  logic [NUM_STAGES-1:0] en;
  logic [DAYS_W-1:0]     days;
  logic [HOUR_W-1:0]     hour_r;
  logic [MINUTE_W-1:0]   minute_r;
  logic [YEAR_W-1:0]     year_r;
  logic [MONTH_W-1:0]    month_r;
  logic [DAY_W-1:0]      day_r;
  mcc_tag_t              tag;
  logic [COUNT_W-1:0]    count_r;
  logic                  dec_ok;
  logic [YEAR_W-1:0]     year_out;
  logic [MONTH_W-1:0]    month_out;
  logic [DAY_W-1:0]      day_out;
  logic [HOUR_W-1:0]     hour_out;
  logic [MINUTE_W-1:0]   minute_out;

  mcc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .en_o        (en)
  );

  mcc_time_split u_time (
    .clk_i    (clk_i),
    .en_i     (en),
    .count_i  (s_axis_tdata[32:0]),
    .days_o   (days),
    .hour_o   (hour_r),
    .minute_o (minute_r)
  );

  mcc_date_split u_date (
    .clk_i   (clk_i),
    .en_i    (en),
    .days_i  (days),
    .year_o  (year_r),
    .month_o (month_r),
    .day_o   (day_r)
  );

  mcc_count_path u_count (
    .clk_i    (clk_i),
    .en_i     (en),
    .cmd_i    (cmd_e'(s_axis_tuser)),
    .count_i  (s_axis_tdata[32:0]),
    .year_i   (s_axis_tdata[46:33]),
    .month_i  (s_axis_tdata[50:47]),
    .day_i    (s_axis_tdata[55:51]),
    .hour_i   (s_axis_tdata[60:56]),
    .minute_i (s_axis_tdata[66:61]),
    .tag_o    (tag),
    .count_o  (count_r)
  );

  // Calendar fields only on an in-range decode; zero otherwise.
  assign dec_ok     = (tag.cmd == CMD_DECODE) && !tag.range_err;
  assign year_out   = dec_ok ? year_r   : '0;
  assign month_out  = dec_ok ? month_r  : '0;
  assign day_out    = dec_ok ? day_r    : '0;
  assign hour_out   = dec_ok ? hour_r   : '0;
  assign minute_out = dec_ok ? minute_r : '0;

  assign m_axis_tdata = {5'd0, minute_out, hour_out, day_out, month_out, year_out, count_r};
  assign m_axis_tuser = (tag.cmd == CMD_DECODE) && tag.range_err;

  `MCC_ASSERT_IMP(a_decode_date_range, m_axis_tvalid && dec_ok,
    month_r >= 4'd1 && month_r <= 4'd12 && day_r >= 5'd1 && day_r <= 5'd31
    && year_r >= 14'd1 && year_r <= 14'd9999,
    "decoded date outside the calendar")
  `MCC_ASSERT_IMP(a_decode_time_range, m_axis_tvalid && dec_ok,
    hour_r <= 5'd23 && minute_r <= 6'd59,
    "decoded time of day out of range")

endmodule

// ===== src/mcc_pipe_ctrl.sv =====
// Valid bits and per-stage ready chain for the converter pipeline.
// Depends on mcc_pkg and the converter assertion macros.
`include "minute_count_calendar_converter_defines.svh"

module mcc_pipe_ctrl
  import mcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NUM_STAGES-1:0] en_o
);

  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] valid_q, valid_d, ready;

  // A stage may load when it is empty or its beat moves on.
  always_comb begin
    ready[LAST] = !valid_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = ready;
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[LAST];

  `MCC_ASSERT_IMP(a_bubble_gives_ready, $countones(valid_q) < NUM_STAGES, in_ready_o,
    "pipeline has a free stage but refuses input")
  `MCC_ASSERT_NEXT(a_stall_holds_first, valid_q[0] && !ready[1], valid_q[0],
    "stalled beat lost from first stage")
  `MCC_ASSERT_NEXT(a_accept_fills_first, in_valid_i && in_ready_o, valid_q[0],
    "accepted beat missing from first stage")

endmodule

// ===== src/mcc_time_split.sv =====
// Decode front: minute count to day number, then minutes of day to hour
// and minute. Depends on mcc_pkg.
module mcc_time_split
  import mcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] en_i,
  input  logic [COUNT_W-1:0]    count_i,
  output logic [DAYS_W-1:0]     days_o,
  output logic [HOUR_W-1:0]     hour_o,
  output logic [MINUTE_W-1:0]   minute_o
);

  localparam int ST_HOUR = 2;
  localparam int ST_MIN  = 3;
  localparam int LAST    = NUM_STAGES - 1;

  logic [56:0]         days_prod;
  logic [DAYS_W-1:0]   days_d, days_q;
  logic [10:0]         lo_q;
  logic [5:0]          rem45_d;
  logic [10:0]         rest_d, rest_q, rest3_q;
  logic [22:0]         hour_prod;
  logic [HOUR_W-1:0]   hour_d;
  logic [MINUTE_W-1:0] minute_d;
  logic [HOUR_W-1:0]   hour_q [ST_HOUR:LAST];
  logic [MINUTE_W-1:0] min_q  [ST_MIN:LAST];

  // days = count / 1440 = (count >> 5) / 45
  assign days_prod = 57'(count_i[COUNT_W-1:5]) * 57'(RECIP_45);
  assign days_d    = days_prod[SHIFT_45+DAYS_W-1:SHIFT_45];

  // Remainder below 64, so six bits of the subtraction suffice.
  assign rem45_d = lo_q[10:5] - 6'(days_q[5:0] * 6'd45);
  assign rest_d  = {rem45_d, lo_q[4:0]};

  assign hour_prod = 23'(rest_q) * 23'(RECIP_60);
  assign hour_d    = hour_prod[SHIFT_60+HOUR_W-1:SHIFT_60];

  assign minute_d = 6'(rest3_q - 11'(hour_q[ST_HOUR]) * 11'd60);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      days_q <= days_d;
      lo_q   <= count_i[10:0];
    end
    if (en_i[1]) begin
      rest_q <= rest_d;
    end
    if (en_i[ST_HOUR]) begin
      hour_q[ST_HOUR] <= hour_d;
      rest3_q         <= rest_q;
    end
    if (en_i[ST_MIN]) begin
      min_q[ST_MIN] <= minute_d;
    end
    for (int k = ST_HOUR + 1; k <= LAST; k++) begin
      if (en_i[k]) begin
        hour_q[k] <= hour_q[k-1];
      end
    end
    for (int k = ST_MIN + 1; k <= LAST; k++) begin
      if (en_i[k]) begin
        min_q[k] <= min_q[k-1];
      end
    end
  end

  assign days_o   = days_q;
  assign hour_o   = hour_q[LAST];
  assign minute_o = min_q[LAST];

endmodule

// ===== src/mcc_date_split.sv =====
// Decode back end: day number to year, month and day through the
// 400, 100, 4 and 1 year cycles. Depends on mcc_pkg.
module mcc_date_split
  import mcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] en_i,
  input  logic [DAYS_W-1:0]     days_i,
  output logic [YEAR_W-1:0]     year_o,
  output logic [MONTH_W-1:0]    month_o,
  output logic [DAY_W-1:0]      day_o
);

  localparam int ST_Q    = 1;
  localparam int ST_R400 = 2;
  localparam int ST_C    = 3;
  localparam int ST_F    = 4;
  localparam int ST_Y    = 5;
  localparam int ST_YEAR = 6;
  localparam int ST_DAY  = NUM_STAGES - 1;

  logic [46:0]        q_prod;
  logic [5:0]         q_d;
  logic [5:0]         q_q [ST_Q:ST_YEAR-1];
  logic [DAYS_W-1:0]  days2_q;
  logic [17:0]        r400_d, r400_q;
  logic [1:0]         c_d;
  logic [1:0]         c_q [ST_C:ST_YEAR-1];
  logic [15:0]        r100_d, r100_q, r100_5_q;
  logic [31:0]        f_prod;
  logic [4:0]         f_d;
  logic [4:0]         f_q [ST_F:ST_YEAR-1];
  logic [10:0]        r4;
  logic [1:0]         y_d, y_q;
  logic [8:0]         r1_d;
  logic [8:0]         r1_q [ST_Y:ST_YEAR];
  logic [14:0]        year_sum;
  logic [YEAR_W-1:0]  year_q [ST_YEAR:ST_DAY];
  logic               leap_d, leap_q;
  logic [3:0]         m_d, m_q;
  logic [MONTH_W-1:0] month_d, month_q;
  logic [DAY_W-1:0]   day_d, day_q;

  assign q_prod = 47'(days_i) * 47'(RECIP_400Y);
  assign q_d    = q_prod[SHIFT_400Y+5:SHIFT_400Y];

  assign r400_d = 18'(days2_q - 23'(q_q[ST_Q]) * 23'(DAYS_400Y));

  // The last day of a 400 year cycle clamps to century three.
  assign c_d = 2'({1'b0, r400_q >= 18'd36524} + {1'b0, r400_q >= 18'd73048}
                  + {1'b0, r400_q >= 18'd109572});
  assign r100_d = 16'(r400_q - 18'(c_d) * 18'(DAYS_100Y));

  assign f_prod = 32'(r100_q) * 32'(RECIP_1461);
  assign f_d    = f_prod[SHIFT_1461+4:SHIFT_1461];

  // The last day of a four year cycle clamps to year three.
  assign r4   = 11'(r100_5_q - 16'(f_q[ST_F]) * 16'(DAYS_4Y));
  assign y_d  = 2'({1'b0, r4 >= 11'd365} + {1'b0, r4 >= 11'd730}
                   + {1'b0, r4 >= 11'd1095});
  assign r1_d = 9'(r4 - 11'(y_d) * 11'(DAYS_1Y));

  assign year_sum = 15'(q_q[ST_YEAR-1]) * 15'd400 + 15'(c_q[ST_YEAR-1]) * 15'd100
                  + 15'(f_q[ST_YEAR-1]) * 15'd4 + 15'(y_q) + 15'd1;

  always_comb begin
    leap_d = (y_q == 2'd3) && ((f_q[ST_YEAR-1] != 5'd24) || (c_q[ST_YEAR-1] == 2'd3));
    m_d    = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (cum_days(4'(k), leap_d) <= r1_q[ST_YEAR-1]) begin
        m_d = 4'(k);
      end
    end
  end

  assign month_d = m_q + 4'd1;
  assign day_d   = 5'(r1_q[ST_YEAR] - cum_days(m_q, leap_q) + 9'd1);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_Q]) begin
      q_q[ST_Q] <= q_d;
      days2_q   <= days_i;
    end
    if (en_i[ST_R400]) begin
      r400_q <= r400_d;
    end
    if (en_i[ST_C]) begin
      c_q[ST_C] <= c_d;
      r100_q    <= r100_d;
    end
    if (en_i[ST_F]) begin
      f_q[ST_F] <= f_d;
      r100_5_q  <= r100_q;
    end
    if (en_i[ST_Y]) begin
      y_q       <= y_d;
      r1_q[ST_Y] <= r1_d;
    end
    if (en_i[ST_YEAR]) begin
      year_q[ST_YEAR] <= year_sum[YEAR_W-1:0];
      leap_q          <= leap_d;
      m_q             <= m_d;
      r1_q[ST_YEAR]   <= r1_q[ST_YEAR-1];
    end
    if (en_i[ST_DAY]) begin
      year_q[ST_DAY] <= year_q[ST_DAY-1];
      month_q        <= month_d;
      day_q          <= day_d;
    end
    for (int k = ST_Q + 1; k < ST_YEAR; k++) begin
      if (en_i[k]) begin
        q_q[k] <= q_q[k-1];
      end
    end
    for (int k = ST_C + 1; k < ST_YEAR; k++) begin
      if (en_i[k]) begin
        c_q[k] <= c_q[k-1];
      end
    end
    for (int k = ST_F + 1; k < ST_YEAR; k++) begin
      if (en_i[k]) begin
        f_q[k] <= f_q[k-1];
      end
    end
  end

  assign year_o  = year_q[ST_DAY];
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

// ===== src/mcc_count_path.sv =====
// Encode path and count carry: builds the minute count from calendar
// fields and carries command, range flag and count. Depends on mcc_pkg.
module mcc_count_path
  import mcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] en_i,
  input  cmd_e                  cmd_i,
  input  logic [COUNT_W-1:0]    count_i,
  input  logic [YEAR_W-1:0]     year_i,
  input  logic [MONTH_W-1:0]    month_i,
  input  logic [DAY_W-1:0]      day_i,
  input  logic [HOUR_W-1:0]     hour_i,
  input  logic [MINUTE_W-1:0]   minute_i,
  output mcc_tag_t              tag_o,
  output logic [COUNT_W-1:0]    count_o
);

  localparam int ST_ENC = 3;
  localparam int LAST   = NUM_STAGES - 1;

  cmd_e               cmd_q [NUM_STAGES];
  logic               err_q [NUM_STAGES];
  logic [COUNT_W-1:0] cnt_q [NUM_STAGES];

  logic [YEAR_W-1:0]   year_c, year_q, n_c, n2;
  logic [MONTH_W-1:0]  mon_c, mon_q, mon2_q;
  logic [DAY_W-1:0]    day_c, day_q, day2_q;
  logic [HOUR_W-1:0]   hour_q, hour2_q, hour3_q;
  logic [MINUTE_W-1:0] min_q, min2_q, min3_q;
  logic [28:0]         yq_prod, nq_prod;
  logic [7:0]          yq_q, nq_q;
  logic [22:0]         dty_d, dty_q, d_d, d_q;
  logic                leap_d, leap_q;
  logic [COUNT_W-1:0]  total, cnt_enc_d;

  // Zero fields count as their lowest value, months past December as December.
  always_comb begin
    year_c = (year_i == '0) ? 14'd1 : year_i;
    if (month_i == '0) begin
      mon_c = 4'd1;
    end else if (month_i > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = month_i;
    end
    day_c = (day_i == '0) ? 5'd1 : day_i;
  end

  assign n_c     = year_c - 14'd1;
  assign yq_prod = 29'(year_c) * 29'(RECIP_100);
  assign nq_prod = 29'(n_c) * 29'(RECIP_100);

  // Days before 1 January of the year, and the leap rule from year / 100.
  assign n2     = year_q - 14'd1;
  assign dty_d  = 23'(n2) * 23'd365 + 23'(n2 >> 2) - 23'(nq_q) + 23'(nq_q >> 2);
  assign leap_d = (year_q[1:0] == 2'b00)
               && ((year_q != 14'(yq_q) * 14'd100) || (yq_q[1:0] == 2'b00));

  assign d_d = dty_q + 23'(cum_days(mon2_q - 4'd1, leap_q)) + 23'(day2_q) - 23'd1;

  assign total = 33'(d_q) * 33'(MIN_PER_DAY) + 33'(hour3_q) * 33'd60 + 33'(min3_q);
  assign cnt_enc_d = (cmd_q[ST_ENC-1] == CMD_ENCODE) ? total : cnt_q[ST_ENC-1];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cmd_q[0] <= cmd_i;
      err_q[0] <= count_i > MAX_COUNT;
      cnt_q[0] <= count_i;
      year_q   <= year_c;
      yq_q     <= yq_prod[SHIFT_100+7:SHIFT_100];
      nq_q     <= nq_prod[SHIFT_100+7:SHIFT_100];
      mon_q    <= mon_c;
      day_q    <= day_c;
      hour_q   <= hour_i;
      min_q    <= minute_i;
    end
    if (en_i[1]) begin
      dty_q   <= dty_d;
      leap_q  <= leap_d;
      mon2_q  <= mon_q;
      day2_q  <= day_q;
      hour2_q <= hour_q;
      min2_q  <= min_q;
    end
    if (en_i[2]) begin
      d_q     <= d_d;
      hour3_q <= hour2_q;
      min3_q  <= min2_q;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en_i[k]) begin
        cmd_q[k] <= cmd_q[k-1];
        err_q[k] <= err_q[k-1];
        // Swap in the built count on encode beats.
        cnt_q[k] <= (k == ST_ENC) ? cnt_enc_d : cnt_q[k-1];
      end
    end
  end

  assign tag_o   = '{cmd: cmd_q[LAST], range_err: err_q[LAST]};
  assign count_o = cnt_q[LAST];

endmodule

// ===== test/minute_count_calendar_converter_test.sv =====
// Self-checking bench for the minute count calendar converter: directed and random
// decode and encode beats against an in-bench calendar predictor, with random
// sender gaps and receiver stalls. Depends on mcc_pkg and the converter top level.
module minute_count_calendar_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcc_pkg::TDATA_W;
  import mcc_pkg::NUM_STAGES;
  import mcc_pkg::cmd_e;
  import mcc_pkg::CMD_DECODE;
  import mcc_pkg::CMD_ENCODE;

  localparam int unsigned DAY_MINUTES   = 1440;
  localparam int unsigned ERA_DAYS      = 146097;
  localparam int unsigned CENTURY_DAYS  = 36524;
  localparam int unsigned QUAD_DAYS     = 1461;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam longint unsigned LAST_VALID_COUNT = 64'd5258964959;
  localparam int unsigned MONTH_START [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int RANDOM_BEATS = 650;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic       range_err;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [13:0] year;
    logic [32:0] count;
  } calendar_t;

  typedef struct {
    cmd_e               cmd;
    logic [TDATA_W-1:0] data;
    bit                 drain_first;
  } request_t;

  typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;

  request_t  beats_to_send [$];
  calendar_t pending_results [$];
  int        beats_accepted = 0;
  int        total_beats = 0;
  int        errors = 0;
  int        cycle_count = 0;
  bit        beat_sent = 1'b0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        hold_cycles = 0;
  bit        long_hold_done = 1'b0;
  rx_mode_e  rx_mode = RX_FREE;
  int        rx_mode_left = 0;

  minute_count_calendar_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_start(input int unsigned k, input bit leap);
    return MONTH_START[k] + ((leap && k >= 2) ? 1 : 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned mo);
    if (mo == 12) begin
      return 31;
    end
    return month_start(mo, is_leap(y)) - month_start(mo - 1, is_leap(y));
  endfunction

  function automatic logic [TDATA_W-1:0] beat_of(input logic [32:0] cnt,
                                                 input logic [13:0] y,
                                                 input logic [3:0] mo,
                                                 input logic [4:0] d,
                                                 input logic [4:0] h,
                                                 input logic [5:0] mi);
    return {5'd0, mi, h, d, mo, y, cnt};
  endfunction

  function automatic calendar_t calendar_convert(input cmd_e cmd,
                                                 input logic [TDATA_W-1:0] d);
    calendar_t         r;
    longint unsigned   cnt;
    longint unsigned   n;
    longint unsigned   total;
    int unsigned       days, rest, q, rem, c, f, y, yr, m, mon, dy, hr, mi;
    bit                leap;
    r = '0;
    cnt = 64'(d[32:0]);
    r.count = d[32:0];
    if (cmd == CMD_DECODE) begin
      // out of range: echo the count, flag it, leave the fields clear
      if (cnt > LAST_VALID_COUNT) begin
        r.range_err = 1'b1;
        return r;
      end
      days = 32'(cnt / DAY_MINUTES);
      rest = 32'(cnt % DAY_MINUTES);
      q = days / ERA_DAYS;
      rem = days % ERA_DAYS;
      c = rem / CENTURY_DAYS;
      if (c > 3) c = 3;
      rem -= c * CENTURY_DAYS;
      f = rem / QUAD_DAYS;
      rem -= f * QUAD_DAYS;
      y = rem / YEAR_DAYS;
      if (y > 3) y = 3;
      rem -= y * YEAR_DAYS;
      yr = q * 400 + c * 100 + f * 4 + y + 1;
      leap = is_leap(yr);
      m = 0;
      for (int k = 1; k < 12; k++) begin
        if (month_start(k, leap) <= rem) m = k;
      end
      r.year = 14'(yr);
      r.month = 4'(m + 1);
      r.day = 5'(rem - month_start(m, leap) + 1);
      r.hour = 5'(rest / 60);
      r.minute = 6'(rest % 60);
    end else begin
      yr = 32'(d[46:33]);
      mon = 32'(d[50:47]);
      dy = 32'(d[55:51]);
      hr = 32'(d[60:56]);
      mi = 32'(d[66:61]);
      if (yr == 0) yr = 1;
      if (mon == 0) mon = 1;
      if (mon > 12) mon = 12;
      if (dy == 0) dy = 1;
      n = 64'(yr - 1);
      total = n * YEAR_DAYS + n / 4 - n / 100 + n / 400
              + 64'(month_start(mon - 1, is_leap(yr))) + 64'(dy - 1);
      total = total * DAY_MINUTES + 64'(hr * 60 + mi);
      r.count = total[32:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] count_of(input int unsigned y, input int unsigned mo,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi);
    calendar_t r;
    r = calendar_convert(CMD_ENCODE, beat_of('0, 14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi)));
    return r.count;
  endfunction

  task automatic queue_decode(input logic [32:0] cnt, input bit drain = 1'b0);
    request_t req;
    req.cmd = CMD_DECODE;
    req.data = beat_of(cnt, 14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                       6'($urandom));
    req.drain_first = drain;
    beats_to_send.push_back(req);
  endtask

  task automatic queue_encode(input int unsigned y, input int unsigned mo,
                              input int unsigned d, input int unsigned h,
                              input int unsigned mi, input bit drain = 1'b0);
    request_t    req;
    logic [32:0] junk;
    junk[31:0] = $urandom;
    junk[32] = 1'($urandom_range(0, 1));
    req.cmd = CMD_ENCODE;
    req.data = beat_of(junk, 14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi));
    req.drain_first = drain;
    beats_to_send.push_back(req);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: offer beats from the queue in bursts, hold a beat until it is taken
  always @(negedge clk_i) begin
    logic     offer;
    request_t req;
    offer = s_axis_tvalid;
    if (!rst_ni) begin
      offer = 1'b0;
    end else if (!s_axis_tvalid || beat_sent) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (beats_to_send.size() > 0 &&
                   !(beats_to_send[0].drain_first && pending_results.size() > 0)) begin
        req = beats_to_send.pop_front();
        s_axis_tdata <= req.data;
        s_axis_tuser <= req.cmd;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    s_axis_tvalid <= offer;
  end

  // Receiver: stall in random modes, with one long hold-off mid-run
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_cycles > 0) begin
      hold_cycles--;
      rdy = 1'b0;
    end else if (!long_hold_done && beats_accepted >= 300) begin
      long_hold_done = 1'b1;
      hold_cycles = 400;
      rdy = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(8, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_HALF:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = ($urandom_range(0, 7) != 0);
      endcase
    end
    m_axis_tready <= rdy;
  end

  // Monitor: predict on each accepted input beat, compare each accepted output beat
  always @(posedge clk_i) begin
    calendar_t got;
    calendar_t want;
    beat_sent <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(calendar_convert(cmd_e'(s_axis_tuser), s_axis_tdata));
      beats_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[66:0]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual count %0d",
                 $time, got.count);
      end else begin
        want = pending_results.pop_front();
        check_field("count_out", want.count, got.count);
        check_field("year_out", want.year, got.year);
        check_field("month_out", want.month, got.month);
        check_field("day_out", want.day, got.day);
        check_field("hour_out", want.hour, got.hour);
        check_field("minute_out", want.minute, got.minute);
        check_field("range_error", want.range_err, got.range_err);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned y, mo, d, h, mi, pick;
    logic [32:0] cnt;
    bit          drain;

    // extremes of the count and range edge
    queue_decode(33'd0);
    queue_decode(33'(LAST_VALID_COUNT));
    queue_decode(33'(LAST_VALID_COUNT + 1));
    queue_decode('1);
    // leap rules: fourth year, skipped century, four-hundredth year
    queue_decode(count_of(2000, 2, 29, 12, 34));
    queue_decode(count_of(1900, 3, 1, 0, 0));
    queue_decode(count_of(2400, 12, 31, 23, 59));
    queue_decode(count_of(2100, 12, 31, 23, 59));
    queue_decode(count_of(2004, 12, 31, 0, 1));
    queue_decode(count_of(1, 12, 31, 23, 59));
    queue_encode(1, 1, 1, 0, 0);
    queue_encode(9999, 12, 31, 23, 59);
    // clamped fields: zero year, month and day, month past December
    queue_encode(0, 0, 0, 0, 0);
    queue_encode(2023, 15, 10, 8, 30);
    // overlong day, hour and minute roll forward
    queue_encode(2001, 2, 31, 5, 5);
    queue_encode(1900, 2, 29, 0, 0);
    queue_encode(2000, 2, 29, 0, 0);
    queue_encode(2400, 12, 31, 23, 59);
    queue_encode(1999, 6, 15, 31, 63);
    // count wraps past 33 bits, then year 9999 with fields past their range
    queue_encode(16383, 15, 31, 31, 63);
    queue_encode(9999, 15, 31, 31, 63);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      drain = (i == 200 || i == 450);
      pick = $urandom_range(0, 99);
      cnt[31:0] = $urandom;
      cnt[32] = 1'($urandom_range(0, 1));
      y = ($urandom_range(0, 2) == 0) ? 100 * $urandom_range(1, 99) : $urandom_range(1, 9999);
      mo = $urandom_range(1, 12);
      if (pick < 30) begin
        queue_decode(33'(longint'(cnt) % (LAST_VALID_COUNT + 1)), drain);
      end else if (pick < 45) begin
        // land on or next to a month, year or day edge
        d = ($urandom_range(0, 1) == 0) ? 1 : month_days(y, mo);
        h = ($urandom_range(0, 1) == 0) ? 0 : 23;
        mi = (h == 0) ? 0 : 59;
        cnt = count_of(y, mo, d, h, mi);
        case ($urandom_range(0, 2))
          0:       cnt = cnt - 33'd1;
          1:       cnt = cnt + 33'd1;
          default: cnt = cnt;
        endcase
        queue_decode(cnt, drain);
      end else if (pick < 50) begin
        queue_decode(cnt, drain);
      end else if (pick < 85) begin
        queue_encode(y, mo, $urandom_range(1, month_days(y, mo)), $urandom_range(0, 23),
                     $urandom_range(0, 59), drain);
      end else begin
        queue_encode($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), drain);
      end
    end
    total_beats = beats_to_send.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_accepted < total_beats) @(negedge clk_i);
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (NUM_STAGES * 4) @(negedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
